// ===== hw/rtl/ctadj_pkg.sv =====
// ----------------------------------------------------------------------------
// Color temperature adjust package
// Port payload types, pipeline tag, fixed constants and the gamma decode ROM
// builder shared by the color temperature adjust modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctadj_pkg;

	// One input pixel, gamma encoded.
	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       end_of_image;
	} ctadj_pixel_t;

	// One adjusted pixel, gamma encoded.
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       end_of_image_out;
	} ctadj_result_t;

	// Control that travels with each pixel down the pipeline.
	typedef struct packed {
		logic valid;
		logic eoi;
	} ctadj_tag_t;

	// Decode ROM: linear value of each 8-bit code, right aligned.
	typedef logic [31:0] ctadj_dec_rom_t [256];

	// Mixing coefficients in units of 1/COEF_SCALE.
	localparam int unsigned COEF_SELF  = 108;
	localparam int unsigned COEF_CROSS = 288;
	localparam int unsigned COEF_OTHER = 216;
	localparam int unsigned COEF_SCALE = 10000;
	localparam int unsigned COEF_ROUND = 5000;

	// Gain is GAIN_NUM / kelvin - GAIN_OFFSET.
	localparam int unsigned GAIN_NUM     = 10000;
	localparam int unsigned GAIN_OFFSET  = 10;
	localparam int unsigned KELVIN_RESET = 6500;

	// Truncated fifth power of a Q32 value.
	function automatic longint unsigned ctadj_pow5_q32(input longint unsigned y);
		longint unsigned m;
		m = y;
		for (int n = 0; n < 4; n++) begin
			m = (m * y) >> 32;
		end
		return m;
	endfunction

	// Builds the gamma 2.2 decode table at elaboration. The Q32 fifth root
	// found by bit search gives x^2.2 as x^2 * x^(1/5).
	function automatic ctadj_dec_rom_t ctadj_decode_rom(input int unsigned frac_bits);
		ctadj_dec_rom_t  rom;
		longint unsigned u;
		longint unsigned root;
		longint unsigned cand;
		longint unsigned sq;
		longint unsigned w;
		for (int unsigned i = 0; i < 256; i++) begin
			if (i == 0) begin
				rom[i] = 32'd0;
			end else if (i == 255) begin
				rom[i] = 32'(64'd1 << frac_bits);
			end else begin
				u = {32'(i), 32'd0} / 64'd255;
				root = 64'd0;
				for (int b = 31; b >= 0; b--) begin
					cand = root | (64'd1 << b);
					if (ctadj_pow5_q32(cand) <= u) begin
						root = cand;
					end
				end
				sq = (u * u) >> 32;
				w = (sq * root) >> 32;
				w = (w + (64'd1 << (31 - frac_bits))) >> (32 - frac_bits);
				rom[i] = w[31:0];
			end
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ctadj_delta_div.sv =====
// ----------------------------------------------------------------------------
// Mixing gain divider
// Holds the mixing gain and recomputes it after each temperature write with a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctadj_delta_div
	import ctadj_pkg::*;
#(
	parameter int unsigned LINEAR_FRACTION_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [15:0]                          cfg_wdata,
	output logic                                 busy,
	output logic signed [LINEAR_FRACTION_BITS+14:0] delta
);

	localparam int unsigned F    = LINEAR_FRACTION_BITS;
	localparam int unsigned NW   = F + 14;
	localparam int unsigned DW   = F + 15;
	localparam int unsigned CNTW = $clog2(NW + 1);

	localparam logic [NW-1:0] DIVIDEND    = NW'(64'(GAIN_NUM) << F);
	localparam logic [DW-1:0] OFFSET_LIN  = DW'(64'(GAIN_OFFSET) << F);
	localparam logic [DW-1:0] DELTA_RESET =
		DW'((64'(GAIN_NUM) << F) / 64'(KELVIN_RESET) - (64'(GAIN_OFFSET) << F));

	logic [NW-1:0]        quot_q;
	logic [NW-1:0]        quot_nx;
	logic [15:0]          rem_q;
	logic [15:0]          rem_nx;
	logic [15:0]          kelvin_q;
	logic [16:0]          trial;
	logic                 ge;
	logic [CNTW-1:0]      cnt_q;
	logic                 busy_q;
	logic signed [DW-1:0] delta_q;

	// One restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		trial   = {rem_q, quot_q[NW-1]};
		ge      = trial >= {1'b0, kelvin_q};
		rem_nx  = ge ? 16'(trial - {1'b0, kelvin_q}) : trial[15:0];
		quot_nx = {quot_q[NW-2:0], ge};
	end

	// Control and the gain register. A write restarts the division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			delta_q <= DELTA_RESET;
		end else if (cfg_we) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q  <= 1'b0;
				delta_q <= {1'b0, quot_nx} - OFFSET_LIN;
			end
		end
	end

	// Divider datapath. A temperature of zero divides as one.
	always_ff @(posedge clk) begin
		if (cfg_we) begin
			kelvin_q <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
			quot_q   <= DIVIDEND;
			rem_q    <= '0;
		end else if (busy_q) begin
			quot_q <= quot_nx;
			rem_q  <= rem_nx;
		end
	end

	assign busy  = busy_q;
	assign delta = delta_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ctadj_mix.sv =====
// ----------------------------------------------------------------------------
// Channel mixer
// Four-stage pipeline that updates one linear channel from itself and two
// others: a + floor(delta * floor((k1*a - k2*x + k3*y) / 2^F) / 2^F),
// saturated to [-8, 8). The other two channels ride along unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module ctadj_mix
	import ctadj_pkg::*;
#(
	parameter int unsigned LINEAR_FRACTION_BITS = 16
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  ctadj_tag_t                              tag_in,
	input  wire  signed [LINEAR_FRACTION_BITS+3:0]  a_in,
	input  wire  signed [LINEAR_FRACTION_BITS+3:0]  x_in,
	input  wire  signed [LINEAR_FRACTION_BITS+3:0]  y_in,
	input  wire  signed [LINEAR_FRACTION_BITS+14:0] delta,
	output ctadj_tag_t                              tag_out,
	output logic signed [LINEAR_FRACTION_BITS+3:0]  a_out,
	output logic signed [LINEAR_FRACTION_BITS+3:0]  x_out,
	output logic signed [LINEAR_FRACTION_BITS+3:0]  y_out
);

	localparam int unsigned F    = LINEAR_FRACTION_BITS;
	localparam int unsigned LW   = F + 4;
	localparam int unsigned KSW  = F - 3;
	localparam int unsigned PW   = LW + KSW;
	localparam int unsigned SUMW = PW + 2;
	localparam int unsigned SW   = SUMW - F;
	localparam int unsigned DW   = F + 15;
	localparam int unsigned HW   = DW - 16;
	localparam int unsigned PHW  = HW + SW;
	localparam int unsigned PLW  = 17 + SW;
	localparam int unsigned MW   = DW + SW;
	localparam int unsigned UW   = MW - F;
	localparam int unsigned VW   = UW + 1;

	localparam logic signed [KSW-1:0] K_SELF =
		KSW'(((64'(COEF_SELF) << F) + 64'(COEF_ROUND)) / 64'(COEF_SCALE));
	localparam logic signed [KSW-1:0] K_CROSS =
		KSW'(((64'(COEF_CROSS) << F) + 64'(COEF_ROUND)) / 64'(COEF_SCALE));
	localparam logic signed [KSW-1:0] K_OTHER =
		KSW'(((64'(COEF_OTHER) << F) + 64'(COEF_ROUND)) / 64'(COEF_SCALE));
	localparam logic signed [VW-1:0] LIN_MAX = VW'((64'd1 << (F + 3)) - 64'd1);
	localparam logic signed [VW-1:0] LIN_MIN = ~LIN_MAX;

	// Stage registers.
	ctadj_tag_t            tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [LW-1:0]  a_s1, x_s1, y_s1;
	logic signed [LW-1:0]  a_s2, x_s2, y_s2;
	logic signed [LW-1:0]  a_s3, x_s3, y_s3;
	logic signed [LW-1:0]  a_s4, x_s4, y_s4;
	logic signed [PW-1:0]  pa_s1, px_s1, py_s1;
	logic signed [SW-1:0]  s_s2;
	logic signed [PHW-1:0] ph_s3;
	logic signed [PLW-1:0] pl_s3;

	// Combinational values between stages.
	logic signed [SUMW-1:0] sum;
	logic signed [HW-1:0]   d_hi;
	logic signed [16:0]     d_lo;
	logic signed [MW-1:0]   full;
	logic signed [UW-1:0]   upd;
	logic signed [VW-1:0]   vsum;
	logic signed [LW-1:0]   a_sat;

	// The gain is split so that each partial product stays narrow.
	assign d_hi = delta[DW-1:16];
	assign d_lo = {1'b0, delta[15:0]};

	// Weighted sum, floor divided by 2^F.
	assign sum = SUMW'(pa_s1) - SUMW'(px_s1) + SUMW'(py_s1);

	// Recombine the gain product, floor divide by 2^F, add and saturate.
	always_comb begin
		full = (MW'(ph_s3) <<< 16) + MW'(pl_s3);
		upd  = full[MW-1:F];
		vsum = VW'(a_s3) + VW'(upd);
		if (vsum > LIN_MAX) begin
			a_sat = LIN_MAX[LW-1:0];
		end else if (vsum < LIN_MIN) begin
			a_sat = LIN_MIN[LW-1:0];
		end else begin
			a_sat = vsum[LW-1:0];
		end
	end

	// Valid and end-of-image travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		pa_s1 <= PW'(K_SELF) * PW'(a_in);
		px_s1 <= PW'(K_CROSS) * PW'(x_in);
		py_s1 <= PW'(K_OTHER) * PW'(y_in);
		a_s1  <= a_in;
		x_s1  <= x_in;
		y_s1  <= y_in;

		s_s2 <= sum[SUMW-1:F];
		a_s2 <= a_s1;
		x_s2 <= x_s1;
		y_s2 <= y_s1;

		ph_s3 <= PHW'(d_hi) * PHW'(s_s2);
		pl_s3 <= PLW'(d_lo) * PLW'(s_s2);
		a_s3  <= a_s2;
		x_s3  <= x_s2;
		y_s3  <= y_s2;

		a_s4 <= a_sat;
		x_s4 <= x_s3;
		y_s4 <= y_s3;
	end

	assign tag_out = tag_s4;
	assign a_out   = a_s4;
	assign x_out   = x_s4;
	assign y_out   = y_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/ctadj_encode.sv =====
// ----------------------------------------------------------------------------
// Gamma encoder
// Re-encodes three linear channels to 8-bit codes. After clamping, the code
// is the largest code whose decode entry is at or below the quantized value,
// found by a binary search over the decode ROM with one bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ctadj_encode
	import ctadj_pkg::*;
#(
	parameter int unsigned LINEAR_FRACTION_BITS   = 16,
	parameter int unsigned ENCODE_TABLE_ADDR_BITS = 12
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  ctadj_tag_t                             tag_in,
	input  wire  signed [LINEAR_FRACTION_BITS+3:0] lin [3],
	output ctadj_tag_t                             tag_out,
	output logic [7:0]                             code [3]
);

	localparam int unsigned F     = LINEAR_FRACTION_BITS;
	localparam int unsigned E     = ENCODE_TABLE_ADDR_BITS;
	localparam int unsigned LW    = F + 4;
	localparam int unsigned FE    = F + E;
	localparam int unsigned CW    = F + E + 1;
	localparam int unsigned NLANE = 3;
	localparam int unsigned NSTEP = 8;

	localparam ctadj_dec_rom_t DEC_ROM = ctadj_decode_rom(F);
	localparam logic signed [LW-1:0] ONE_LIN = LW'(64'd1 << F);

	// Search state per stage and lane. A locked lane keeps its clamped code.
	ctadj_tag_t   tag_s  [NSTEP+1];
	logic [7:0]   cnt_s  [NSTEP+1][NLANE];
	logic         lock_s [NSTEP][NLANE];
	logic [E-1:0] addr_s [NSTEP][NLANE];

	logic [FE-1:0] scaled [NLANE];

	// Quantize the linear value to a table address.
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			scaled[l] = FE'(lin[l][F-1:0]) << E;
		end
	end

	// Entry stage: clamp at or below zero and at or above one.
	always_ff @(posedge clk) begin
		for (int l = 0; l < NLANE; l++) begin
			addr_s[0][l] <= scaled[l][FE-1:F];
			if (lin[l][LW-1] || (lin[l] == '0)) begin
				cnt_s[0][l]  <= 8'd0;
				lock_s[0][l] <= 1'b1;
			end else if (lin[l] >= ONE_LIN) begin
				cnt_s[0][l]  <= 8'd255;
				lock_s[0][l] <= 1'b1;
			end else begin
				cnt_s[0][l]  <= 8'd0;
				lock_s[0][l] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else begin
			tag_s[0] <= tag_in;
		end
	end

	// Search stages, most significant code bit first.
	for (genvar j = 1; j <= NSTEP; j++) begin : g_step
		localparam int unsigned B = NSTEP - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[j] <= '0;
			end else begin
				tag_s[j] <= tag_s[j-1];
			end
		end

		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			logic [7:0]    cand;
			logic [CW-1:0] lhs;
			logic [CW-1:0] rhs;
			logic          take;

			// Keep the candidate bit if its decode entry is not above the value.
			always_comb begin
				cand = cnt_s[j-1][l] | 8'(1 << B);
				lhs  = CW'(DEC_ROM[cand][F:0]) << E;
				rhs  = CW'(addr_s[j-1][l]) << F;
				take = !lock_s[j-1][l] && (lhs <= rhs);
			end

			always_ff @(posedge clk) begin
				cnt_s[j][l] <= take ? cand : cnt_s[j-1][l];
			end

			if (j < NSTEP) begin : g_carry
				always_ff @(posedge clk) begin
					lock_s[j][l] <= lock_s[j-1][l];
					addr_s[j][l] <= addr_s[j-1][l];
				end
			end
		end
	end

	assign tag_out = tag_s[NSTEP];

	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			code[l] = cnt_s[NSTEP][l];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/color_temperature_adjust_unit.sv =====
// ----------------------------------------------------------------------------
// Color temperature adjust unit
// Shifts the color temperature of an RGB pixel stream: gamma decode, ordered
// channel mixing with a gain set by the target temperature, gamma encode.
//
// Channel   Signals              Transfer
// input     start, busy, pixel   rising edge with start high and busy low
// result    done, result         done high for one cycle, always taken
// config    cfg_we, cfg_wdata    rising edge with cfg_we high
//
// One pixel per clock while busy is low. The pipeline has 1 decode stage,
// 4 stages for each of the three channel mixes, and 9 encode stages.
// A temperature write holds busy high while the bit-serial gain divider runs.
// Reset clears the pipeline valid bits and loads the gain for 6500 K.
// The result side has no back-pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module color_temperature_adjust_unit
	import ctadj_pkg::*;
#(
	parameter int unsigned LINEAR_FRACTION_BITS   = 16,
	parameter int unsigned ENCODE_TABLE_ADDR_BITS = 12
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	output logic          busy,
	input  ctadj_pixel_t  pixel,
	output logic          done,
	output ctadj_result_t result,
	input  wire           cfg_we,
	input  wire  [15:0]   cfg_wdata
);

	localparam int unsigned F  = LINEAR_FRACTION_BITS;
	localparam int unsigned LW = F + 4;
	localparam int unsigned DW = F + 15;

	localparam ctadj_dec_rom_t DEC_ROM = ctadj_decode_rom(F);

	logic                 in_fire;
	logic signed [DW-1:0] delta;

	ctadj_tag_t           tag_s1;
	logic signed [LW-1:0] r_s1, g_s1, b_s1;

	ctadj_tag_t           tag_r, tag_g, tag_b, tag_e;
	logic signed [LW-1:0] r_m1, g_m1, b_m1;
	logic signed [LW-1:0] r_m2, g_m2, b_m2;
	logic signed [LW-1:0] r_m3, g_m3, b_m3;
	logic signed [LW-1:0] enc_lin [3];
	logic [7:0]           code [3];

	assign in_fire = start && !busy;

	// Gain register and its divider.
	ctadj_delta_div #(
		.LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS)
	) u_delta_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.delta     (delta)
	);

	// Decode stage: gamma 2.2 table to linear fixed point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= in_fire;
			tag_s1.eoi   <= pixel.end_of_image;
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= {3'b000, DEC_ROM[pixel.red_in][F:0]};
		g_s1 <= {3'b000, DEC_ROM[pixel.green_in][F:0]};
		b_s1 <= {3'b000, DEC_ROM[pixel.blue_in][F:0]};
	end

	// Red first, from the decoded green and blue.
	ctadj_mix #(
		.LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS)
	) u_mix_red (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_s1),
		.a_in    (r_s1),
		.x_in    (g_s1),
		.y_in    (b_s1),
		.delta   (delta),
		.tag_out (tag_r),
		.a_out   (r_m1),
		.x_out   (g_m1),
		.y_out   (b_m1)
	);

	// Green uses the new red.
	ctadj_mix #(
		.LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS)
	) u_mix_green (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_r),
		.a_in    (g_m1),
		.x_in    (r_m1),
		.y_in    (b_m1),
		.delta   (delta),
		.tag_out (tag_g),
		.a_out   (g_m2),
		.x_out   (r_m2),
		.y_out   (b_m2)
	);

	// Blue uses the new red and green.
	ctadj_mix #(
		.LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS)
	) u_mix_blue (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_g),
		.a_in    (b_m2),
		.x_in    (r_m2),
		.y_in    (g_m2),
		.delta   (delta),
		.tag_out (tag_b),
		.a_out   (b_m3),
		.x_out   (r_m3),
		.y_out   (g_m3)
	);

	assign enc_lin[0] = r_m3;
	assign enc_lin[1] = g_m3;
	assign enc_lin[2] = b_m3;

	// Encode back to gamma codes; its last stage is the output register.
	ctadj_encode #(
		.LINEAR_FRACTION_BITS   (LINEAR_FRACTION_BITS),
		.ENCODE_TABLE_ADDR_BITS (ENCODE_TABLE_ADDR_BITS)
	) u_encode (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_b),
		.lin     (enc_lin),
		.tag_out (tag_e),
		.code    (code)
	);

	assign done                    = tag_e.valid;
	assign result.red_out          = code[0];
	assign result.green_out        = code[1];
	assign result.blue_out         = code[2];
	assign result.end_of_image_out = tag_e.eoi;

endmodule

`default_nettype wire

// ===== hw/rtl/ctadj_checker.sv =====
// ----------------------------------------------------------------------------
// Color temperature adjust checker
// Port-level checks on latency, the end-of-image flag and the busy window
// that follows a temperature write.
// ----------------------------------------------------------------------------
`default_nettype none

module ctadj_checker
	import ctadj_pkg::*;
(
	input wire           clk,
	input wire           arst_n,
	input wire           start,
	input wire           busy,
	input ctadj_pixel_t  pixel,
	input wire           done,
	input ctadj_result_t result,
	input wire           cfg_we
);

	localparam int unsigned LATENCY = 22;

	// Every accepted pixel gives a result after the fixed latency.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted pixel gave no result after the pipeline latency");

	// Every result comes from a pixel accepted one latency earlier.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted pixel");

	// The end-of-image flag comes out with its own pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.end_of_image_out == $past(pixel.end_of_image, LATENCY)))
		else $error("end-of-image flag out of step with its pixel");

	// A temperature write blocks input while the gain is recomputed.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("busy not raised after a temperature write");

	// Busy rises only because of a temperature write.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(cfg_we))
		else $error("busy raised without a temperature write");

endmodule

bind color_temperature_adjust_unit ctadj_checker u_ctadj_checker (.*);

`default_nettype wire
